// ----- src/pwt_pkg.sv -----
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types and constants of the pending wait timeout table.
// ----------------------------------------------------------------------------
package pwt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_TICK   = 3'd2,
		ACT_LOST   = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		KIND_DONE    = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_EXPIRED = 2'd2,
		KIND_LOST    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] socket_id;
		logic [31:0] wait_reason;
		logic [63:0] expire_ms;
		logic [63:0] now_ms;
		logic [31:0] instance_tag;
		logic [31:0] packet_handle;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] socket_id_out;
		logic [31:0] reason_out;
		logic [31:0] instance_out;
		logic [31:0] packet_out;
		logic        last;
	} rsp_item_t;

	typedef struct packed {
		logic [15:0] socket;
		logic [31:0] reason;
		logic [63:0] expiry;
		logic [31:0] instance_tag;
		logic [31:0] packet;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- src/pwt_ram.sv -----
// ----------------------------------------------------------------------------
// pwt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/pending_wait_timeout_table.sv -----
// ----------------------------------------------------------------------------
// pending_wait_timeout_table
// Add goes through ST_ADD and then ST_DONE, which queues the done beat; clear and
// unused codes go straight to ST_DONE. Remove, tick and connection lost scan the
// entry RAM at one entry per cycle while no report beat stalls, then go to
// ST_DONE; report beats that stall hold the scan.
// One action at a time; the next request is taken once the done beat is queued.
// Reset empties the table (count zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
module pending_wait_timeout_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  pwt_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output pwt_pkg::rsp_item_t rsp
);

	import pwt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t          state_q;
	req_item_t       req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] wr_ptr_q;
	logic            valid_s1;
	logic            rsp_valid_q;
	rsp_item_t       rsp_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic             re;
	entry_t           rdata;
	logic             hit;
	logic             report;
	logic             out_free;
	logic             stall;
	logic             full;

	pwt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(rd_ptr_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		case (action_t'(req_q.action))
			ACT_REMOVE: begin
				hit = (rdata.socket == req_q.socket_id) && (rdata.reason == req_q.wait_reason)
					&& (rdata.instance_tag == req_q.instance_tag);
			end
			ACT_TICK: begin
				hit = req_q.now_ms > rdata.expiry;
			end
			default: begin
				hit = rdata.socket == req_q.socket_id;
			end
		endcase
		report   = action_t'(req_q.action) != ACT_REMOVE;
		out_free = !rsp_valid_q || rsp_ready;
		full     = count_q >= CNT_W'(TABLE_DEPTH);
		stall    = valid_s1 && hit && report && !out_free;
		re       = (state_q == ST_SCAN) && !stall && (rd_ptr_q < count_q);

		we    = 1'b0;
		waddr = wr_ptr_q[IDX_W-1:0];
		wdata = rdata;
		if (state_q == ST_ADD && !full) begin
			we                 = 1'b1;
			waddr              = count_q[IDX_W-1:0];
			wdata.socket       = req_q.socket_id;
			wdata.reason       = req_q.wait_reason;
			wdata.expiry       = req_q.expire_ms;
			wdata.instance_tag = req_q.instance_tag;
			wdata.packet       = req_q.packet_handle;
		end else if (state_q == ST_SCAN && !stall && valid_s1 && !hit) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						case (action_t'(req.action))
							ACT_ADD: begin
								state_q <= ST_ADD;
							end
							ACT_REMOVE, ACT_TICK, ACT_LOST: begin
								rd_ptr_q <= '0;
								wr_ptr_q <= '0;
								valid_s1 <= 1'b0;
								state_q  <= ST_SCAN;
							end
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (full) begin
						if (out_free) begin
							rsp_valid_q       <= 1'b1;
							rsp_q.kind        <= KIND_FULL;
							rsp_q.socket_id_out <= req_q.socket_id;
							rsp_q.reason_out  <= req_q.wait_reason;
							rsp_q.instance_out <= req_q.instance_tag;
							rsp_q.packet_out  <= req_q.packet_handle;
							rsp_q.last        <= 1'b0;
							state_q           <= ST_DONE;
						end
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (valid_s1 && hit && report) begin
							rsp_valid_q         <= 1'b1;
							rsp_q.kind          <= (action_t'(req_q.action) == ACT_TICK)
								? KIND_EXPIRED : KIND_LOST;
							rsp_q.socket_id_out <= rdata.socket;
							rsp_q.reason_out    <= rdata.reason;
							rsp_q.instance_out  <= rdata.instance_tag;
							rsp_q.packet_out    <= rdata.packet;
							rsp_q.last          <= 1'b0;
						end
						if (valid_s1 && !hit) begin
							wr_ptr_q <= wr_ptr_q + 1'b1;
						end
						valid_s1 <= re;
						if (re) begin
							rd_ptr_q <= rd_ptr_q + 1'b1;
						end
						if (!valid_s1 && !re) begin
							count_q <= wr_ptr_q;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.kind          <= KIND_DONE;
						rsp_q.socket_id_out <= '0;
						rsp_q.reason_out    <= '0;
						rsp_q.instance_out  <= '0;
						rsp_q.packet_out    <= '0;
						rsp_q.last          <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- bench/pwt_checker.sv -----
// ----------------------------------------------------------------------------
// pwt_checker
// Watches the request and response channels of the pending wait table. It
// keeps a shadow of the table, predicts the response beats of each request
// beat, and compares every response beat field by field in order.
// ----------------------------------------------------------------------------
module pwt_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  pwt_pkg::req_item_t req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  pwt_pkg::rsp_item_t rsp,
	output int                 fail_count,
	output int                 pending,
	output int                 req_beats,
	output int                 rsp_beats
);

	import pwt_pkg::*;

	entry_t    shadow_tbl [TABLE_DEPTH];
	int        shadow_cnt = 0;
	rsp_item_t rsp_expected [$];
	int        errs = 0;

	assign fail_count = errs;

	function automatic rsp_item_t mk_beat(kind_t k, logic [15:0] s, logic [31:0] rs,
			logic [31:0] inst, logic [31:0] pkt, logic l);
		rsp_item_t b;
		b.kind = k;
		b.socket_id_out = s;
		b.reason_out = rs;
		b.instance_out = inst;
		b.packet_out = pkt;
		b.last = l;
		return b;
	endfunction

	function automatic void enqueue_beat(rsp_item_t b);
		rsp_expected = {rsp_expected, b};
	endfunction

	function automatic void predict_action(req_item_t r);
		int   i;
		int   w;
		logic hit;
		w = 0;
		case (r.action)
			ACT_ADD: begin
				if (shadow_cnt >= TABLE_DEPTH) begin
					enqueue_beat(mk_beat(KIND_FULL, r.socket_id, r.wait_reason,
						r.instance_tag, r.packet_handle, 1'b0));
				end else begin
					shadow_tbl[shadow_cnt] = '{socket: r.socket_id, reason: r.wait_reason,
						expiry: r.expire_ms, instance_tag: r.instance_tag,
						packet: r.packet_handle};
					shadow_cnt++;
				end
			end
			ACT_REMOVE, ACT_TICK, ACT_LOST: begin
				for (i = 0; i < shadow_cnt; i++) begin
					if (r.action == ACT_REMOVE)
						hit = shadow_tbl[i].socket == r.socket_id &&
							shadow_tbl[i].reason == r.wait_reason &&
							shadow_tbl[i].instance_tag == r.instance_tag;
					else if (r.action == ACT_TICK)
						hit = r.now_ms > shadow_tbl[i].expiry;
					else
						hit = shadow_tbl[i].socket == r.socket_id;
					if (hit) begin
						if (r.action != ACT_REMOVE)
							enqueue_beat(mk_beat(
								(r.action == ACT_TICK) ? KIND_EXPIRED : KIND_LOST,
								shadow_tbl[i].socket, shadow_tbl[i].reason,
								shadow_tbl[i].instance_tag, shadow_tbl[i].packet, 1'b0));
					end else begin
						shadow_tbl[w] = shadow_tbl[i];
						w++;
					end
				end
				shadow_cnt = w;
			end
			ACT_CLEAR: shadow_cnt = 0;
			default: ;
		endcase
		enqueue_beat(mk_beat(KIND_DONE, '0, '0, '0, '0, 1'b1));
	endfunction

	task automatic cmp_field(string fld, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			errs++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, fld, exp_v, act_v);
		end
	endtask

	task automatic check_beat(rsp_item_t b);
		rsp_item_t e;
		if (rsp_expected.size() == 0) begin
			errs++;
			$display("%0t: unexpected response beat, expected none, got %h", $time, b);
		end else begin
			e = rsp_expected.pop_front();
			cmp_field("kind", e.kind, b.kind);
			cmp_field("socket_id_out", e.socket_id_out, b.socket_id_out);
			cmp_field("reason_out", e.reason_out, b.reason_out);
			cmp_field("instance_out", e.instance_out, b.instance_out);
			cmp_field("packet_out", e.packet_out, b.packet_out);
			cmp_field("last", e.last, b.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_expected.delete();
			shadow_cnt = 0;
			pending <= 0;
			req_beats <= 0;
			rsp_beats <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				check_beat(rsp);
				rsp_beats <= rsp_beats + 1;
			end
			if (req_valid && req_ready) begin
				predict_action(req);
				req_beats <= req_beats + 1;
			end
			pending <= rsp_expected.size();
		end
	end

endmodule

// ----- bench/pending_wait_timeout_table_tb.sv -----
// ----------------------------------------------------------------------------
// pending_wait_timeout_table_tb
// Drives the pending wait table with directed corner cases, then random
// action mixes under several idle/stall patterns and a long response hold.
// Prediction and checking live in pwt_checker.
// ----------------------------------------------------------------------------
module pending_wait_timeout_table_tb;
	import pwt_pkg::*;

	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [15:0] sock;
		logic [31:0] reason;
		logic [31:0] inst;
	} wait_key_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	int fail_count;
	int pending;
	int req_beats;
	int rsp_beats;

	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_requests = 0;
	logic [63:0] clock_ms;
	wait_key_t   recent_keys [$];

	pending_wait_timeout_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	pwt_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.req_beats(req_beats),
		.rsp_beats(rsp_beats)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("pending_wait_timeout_table regression: fail");
		$finish;
	end

	// response side: random stalls, plus one long hold on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [15:0] pool_socket(int idx);
		case (idx)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h2C4A;
			default: return 16'h0513;
		endcase
	endfunction

	function automatic logic [31:0] pool_reason(int idx);
		case (idx)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return 32'h0000_0107;
		endcase
	endfunction

	function automatic logic [31:0] pool_inst(int idx);
		case (idx)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return 32'h8000_0001;
		endcase
	endfunction

	function automatic req_item_t mk_req(logic [2:0] act, logic [15:0] s, logic [31:0] rs,
			logic [63:0] exp_ms, logic [63:0] now, logic [31:0] inst, logic [31:0] pkt);
		req_item_t r;
		r.action = act;
		r.socket_id = s;
		r.wait_reason = rs;
		r.expire_ms = exp_ms;
		r.now_ms = now;
		r.instance_tag = inst;
		r.packet_handle = pkt;
		return r;
	endfunction

	function automatic req_item_t random_req(int add_pct);
		req_item_t r;
		wait_key_t k;
		int        pick;
		r.socket_id = ($urandom_range(99) < 85) ? pool_socket($urandom_range(3))
			: 16'($urandom);
		r.wait_reason = ($urandom_range(99) < 85) ? pool_reason($urandom_range(2)) : $urandom;
		r.instance_tag = ($urandom_range(99) < 85) ? pool_inst($urandom_range(2)) : $urandom;
		r.expire_ms = {$urandom, $urandom};
		r.now_ms = {$urandom, $urandom};
		r.packet_handle = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
		pick = $urandom_range(99);
		if (pick < add_pct) begin
			r.action = ACT_ADD;
			case ($urandom_range(19))
				0: r.expire_ms = '0;
				1: r.expire_ms = '1;
				2: ;
				default: r.expire_ms = clock_ms + $urandom_range(300);
			endcase
			k = '{r.socket_id, r.wait_reason, r.instance_tag};
			recent_keys = {recent_keys, k};
			if (recent_keys.size() > 32)
				void'(recent_keys.pop_front());
		end else if (pick < add_pct + 15) begin
			r.action = ACT_REMOVE;
			if (recent_keys.size() != 0 && $urandom_range(9) < 7) begin
				k = recent_keys[$urandom_range(recent_keys.size() - 1)];
				r.socket_id = k.sock;
				r.wait_reason = k.reason;
				r.instance_tag = k.inst;
			end
		end else if (pick < add_pct + 30) begin
			r.action = ACT_TICK;
			clock_ms = clock_ms + $urandom_range(150);
			case ($urandom_range(19))
				0: r.now_ms = '0;
				1: r.now_ms = '1;
				2: ;
				default: r.now_ms = clock_ms;
			endcase
		end else if (pick < add_pct + 42) begin
			r.action = ACT_LOST;
		end else if (pick < add_pct + 49) begin
			r.action = ACT_CLEAR;
		end else begin
			r.action = 3'($urandom_range(7, 5));
		end
		return r;
	endfunction

	task automatic send_req(req_item_t r);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_phase(int idle, int stall, int add_pct, int n_items);
		req_item_t r;
		int        sent;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			r = random_req(add_pct);
			send_req(r);
			sent++;
		end
	endtask

	initial begin
		int i;
		req_valid <= 1'b0;
		req <= '0;
		arst_n <= 1'b0;
		clock_ms = {2'b00, 30'($urandom), 32'($urandom)};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: only done beats
		send_req(mk_req(ACT_TICK, '0, '0, '0, '1, '0, '0));
		send_req(mk_req(ACT_REMOVE, '0, '0, '0, '0, '0, '0));
		send_req(mk_req(3'd5, '1, '1, '1, '1, '1, '1));
		send_req(mk_req(3'd7, '0, '0, '0, '0, '0, '0));

		// fill to depth, with all-zero and all-one entries at the front
		send_req(mk_req(ACT_ADD, '0, '0, '0, '0, '0, '0));
		send_req(mk_req(ACT_ADD, '1, '1, '1, '0, '1, '1));
		for (i = 2; i < TABLE_DEPTH; i++)
			send_req(mk_req(ACT_ADD, pool_socket(i % 4), pool_reason(i % 3),
				64'(i * 1000), '0, pool_inst(i % 3), 32'(i)));
		send_req(mk_req(ACT_ADD, 16'h5A5A, 32'hA5A5_A5A5, 64'h1, '0, 32'h1234_5678,
			32'hDEAD_BEEF));

		// remove hits two entries with the same key
		send_req(mk_req(ACT_REMOVE, pool_socket(2), pool_reason(2), '0, '0, pool_inst(2), '0));
		send_req(mk_req(ACT_TICK, '0, '0, '0, 64'h8000_0000_0000_0000, '0, '0));
		send_req(mk_req(ACT_LOST, 16'hFFFF, '0, '0, '0, '0, '0));
		send_req(mk_req(ACT_CLEAR, '0, '0, '0, '0, '0, '0));
		drain();

		run_phase(0, 0, 44, 19);
		drain();
		run_phase(61, 0, 44, 19);
		drain();
		run_phase(0, 61, 44, 19);
		drain();
		run_phase(25, 25, 70, 19);
		drain();

		// response side held off while requests keep coming
		hold_requests++;
		run_phase(0, 0, 60, 19);
		drain();
		repeat (30) @(posedge clk);

		$display("Covered %0d request beats and %0d response beats: corner cases, full table,",
			req_beats, rsp_beats);
		$display("four idle/stall mixes and a %0d-cycle response hold.", HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("pending_wait_timeout_table regression: pass");
		else
			$display("pending_wait_timeout_table regression: fail");
		$finish;
	end

endmodule
